// ----- hdl/pllt_pkg.sv -----
// Shared types and constants for the angle and speed tracking loop.
`timescale 1ns / 1ps

package pllt_pkg;

    // Register indexes on the configuration write port.
    localparam logic [1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [1:0] REG_INTEG_GAIN    = 2'd1;
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [23:0] PROP_GAIN_RST     = 24'd0;
    localparam logic [31:0] INTEG_GAIN_RST    = 32'd0;
    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd839;

    // Operand and product widths of the shared multiplier.
    localparam int unsigned MUL_OP_W   = 33;
    localparam int unsigned MUL_PROD_W = 2 * MUL_OP_W;

    // Sequencer states; each state from ST_PMUL to ST_AHI issues one multiplier operation.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PMUL,
        ST_SUM,
        ST_HI,
        ST_LO,
        ST_ALO,
        ST_AHI,
        ST_QUOT,
        ST_UPD
    } state_t;

endpackage

// ----- hdl/pllt_mul.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module pllt_mul (
    input  logic                                   aclk,
    input  logic signed [pllt_pkg::MUL_OP_W-1:0]   op_a,
    input  logic signed [pllt_pkg::MUL_OP_W-1:0]   op_b,
    output logic signed [pllt_pkg::MUL_PROD_W-1:0] prod
);
    import pllt_pkg::*;

    logic signed [MUL_PROD_W-1:0] prod_reg;

    // One product per cycle, available the cycle after the operands.
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ----- hdl/pll_angle_speed_tracker_core.sv -----
// Top level of the phase-locked loop that tracks a sensor angle and its speed.
//
//  Channel  Direction  Payload (lowest bits first)
//  s_       in         tdata: phase_in
//  m_       out        tdata: phase_out, speed_out, error_out
//  cfg_     in         index 0 prop_gain, 1 integ_gain, 2 sample_period
//
// Each sample passes from its transfer to its result through the accept
// cycle, six passes through the single 33x33 multiplier, a quotient step
// and the state update. The block takes no new sample until the update is done.
// A finished result waits in the output register; the update of the next
// sample stalls only while that register is still full.
// Reset is synchronous and active low; it clears the estimates and loads the
// register defaults.
`timescale 1ns / 1ps

module pll_angle_speed_tracker_core #(
    parameter int ANGLE_BITS = 16,
    parameter int SPEED_BITS = 48
) (
    input  logic                                                      aclk,
    input  logic                                                      aresetn,
    // Input transfer
    input  logic                                                      s_tvalid,
    output logic                                                      s_tready,
    // tdata: phase_in
    input  logic [((ANGLE_BITS + 7) / 8) * 8 - 1:0]                   s_tdata,
    // Result transfer
    output logic                                                      m_tvalid,
    input  logic                                                      m_tready,
    // tdata: phase_out, speed_out, error_out
    output logic [((2 * ANGLE_BITS + SPEED_BITS + 7) / 8) * 8 - 1:0]  m_tdata,
    // Configuration writes
    input  logic                                                      cfg_we,
    input  logic [1:0]                                                cfg_index,
    input  logic [31:0]                                               cfg_wdata
);
    import pllt_pkg::*;

    localparam int OUT_W = ((2 * ANGLE_BITS + SPEED_BITS + 7) / 8) * 8;
    localparam int FRAC_W = 32 - ANGLE_BITS;
    // Width that holds the speed plus any speed step without overflow.
    localparam int SAT_W = ((SPEED_BITS > 47) ? SPEED_BITS : 47) + 1;
    localparam logic [SAT_W-1:0] SPEED_MAX =
        {{(SAT_W - SPEED_BITS + 1){1'b0}}, {(SPEED_BITS - 1){1'b1}}};
    localparam logic [SAT_W-1:0] SPEED_MIN =
        {{(SAT_W - SPEED_BITS + 1){1'b1}}, {(SPEED_BITS - 1){1'b0}}};

    state_t state_reg, state_next;

    logic [23:0] prop_gain_reg;
    logic [31:0] integ_gain_reg;
    logic [15:0] sample_period_reg;

    logic [31:0]                  phase_reg;
    logic signed [SPEED_BITS-1:0] speed_reg;

    logic [31:0] err_reg;
    logic [55:0] sum_reg;
    logic [63:0] kprod_reg;
    logic [31:0] inc_reg;
    logic [15:0] carry_reg;
    logic        rem_reg;
    logic [44:0] quo_reg;

    logic                  m_tvalid_reg;
    logic [ANGLE_BITS-1:0] m_phase_reg;
    logic [SPEED_BITS-1:0] m_speed_reg;
    logic [ANGLE_BITS-1:0] m_err_reg;

    logic signed [MUL_OP_W-1:0]   mul_a, mul_b;
    logic signed [MUL_PROD_W-1:0] prod;

    logic [31:0]        meas;
    logic [31:0]        err_mag;
    logic               err_neg;
    logic signed [53:0] pterm;
    logic [63:0]        sum_full;
    logic [48:0]        quo_full;
    logic [SAT_W-1:0]   step_add;
    logic [SAT_W-1:0]   speed_sum;
    logic [SAT_W-1:0]   speed_sat;
    logic [31:0]        phase_new;
    logic               out_free;
    logic               in_xfer;

    // Shared multiplier.
    pllt_mul u_mul (
        .aclk  (aclk),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .prod  (prod)
    );

    // Error and its magnitude.
    assign meas    = {s_tdata[ANGLE_BITS-1:0], {FRAC_W{1'b0}}};
    assign err_neg = err_reg[31];
    assign err_mag = err_neg ? (32'd0 - err_reg) : err_reg;
    assign in_xfer = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Speed plus floored proportional term, modulo 2^64.
    assign pterm    = prod[65:12];
    assign sum_full = 64'(speed_reg) + 64'(pterm);

    // Speed step quotient from the high partial product and the carried bits.
    assign quo_full = 49'(prod[47:0]) + 49'(carry_reg);

    // A negative step is -(q + rem), added as ~q plus one when exact.
    assign step_add  = err_neg ? ~SAT_W'(quo_reg) : SAT_W'(quo_reg);
    assign speed_sum = SAT_W'(speed_reg) + step_add + SAT_W'(err_neg && !rem_reg);
    always_comb begin
        priority if ($signed(speed_sum) > $signed(SPEED_MAX)) begin
            speed_sat = SPEED_MAX;
        end else if ($signed(speed_sum) < $signed(SPEED_MIN)) begin
            speed_sat = SPEED_MIN;
        end else begin
            speed_sat = speed_sum;
        end
    end

    assign phase_new = phase_reg + inc_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                state_next = ST_PMUL;
            end
            ST_PMUL: state_next = ST_SUM;
            ST_SUM:  state_next = ST_HI;
            ST_HI:   state_next = ST_LO;
            ST_LO:   state_next = ST_ALO;
            ST_ALO:  state_next = ST_AHI;
            ST_AHI:  state_next = ST_QUOT;
            ST_QUOT: state_next = ST_UPD;
            ST_UPD:  if (out_free) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and multiplier operand selection.
    always_comb begin
        s_tready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_PMUL: begin
                mul_a = MUL_OP_W'($signed(err_reg));
                mul_b = MUL_OP_W'(prop_gain_reg);
            end
            ST_SUM: begin
                mul_a = MUL_OP_W'(integ_gain_reg);
                mul_b = MUL_OP_W'(err_mag);
            end
            ST_HI: begin
                mul_a = MUL_OP_W'(sum_reg[55:24]);
                mul_b = MUL_OP_W'(sample_period_reg);
            end
            ST_LO: begin
                mul_a = MUL_OP_W'(sum_reg[23:0]);
                mul_b = MUL_OP_W'(sample_period_reg);
            end
            ST_ALO: begin
                mul_a = MUL_OP_W'(kprod_reg[31:0]);
                mul_b = MUL_OP_W'(sample_period_reg);
            end
            ST_AHI: begin
                mul_a = MUL_OP_W'(kprod_reg[63:32]);
                mul_b = MUL_OP_W'(sample_period_reg);
            end
            ST_QUOT, ST_UPD: begin
                mul_a = '0;
                mul_b = '0;
            end
            default: s_tready = 1'b0;
        endcase
    end

    // Control state, configuration and loop estimates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            prop_gain_reg     <= PROP_GAIN_RST;
            integ_gain_reg    <= INTEG_GAIN_RST;
            sample_period_reg <= SAMPLE_PERIOD_RST;
            phase_reg         <= '0;
            speed_reg         <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_PROP_GAIN:     prop_gain_reg     <= cfg_wdata[23:0];
                    REG_INTEG_GAIN:    integ_gain_reg    <= cfg_wdata;
                    REG_SAMPLE_PERIOD: sample_period_reg <= cfg_wdata[15:0];
                    default:           prop_gain_reg     <= prop_gain_reg;
                endcase
            end
            if (state_reg == ST_UPD && out_free) begin
                phase_reg    <= phase_new;
                speed_reg    <= speed_sat[SPEED_BITS-1:0];
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            err_reg <= meas - phase_reg;
        end
        unique case (state_reg)
            ST_SUM:  sum_reg   <= sum_full[55:0];
            ST_HI:   kprod_reg <= prod[63:0];
            ST_LO:   inc_reg   <= prod[31:0];
            ST_ALO:  inc_reg   <= inc_reg + 32'(prod[39:24]);
            ST_AHI: begin
                carry_reg <= prod[47:32];
                rem_reg   <= |prod[31:0];
            end
            ST_QUOT: begin
                quo_reg <= quo_full[48:4];
                rem_reg <= rem_reg || (|quo_full[3:0]);
            end
            ST_UPD: if (out_free) begin
                m_phase_reg <= phase_new[31 -: ANGLE_BITS];
                m_speed_reg <= speed_sat[SPEED_BITS-1:0];
                m_err_reg   <= err_reg[31 -: ANGLE_BITS];
            end
            default: sum_reg <= sum_reg;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({m_err_reg, m_speed_reg, m_phase_reg});

`ifndef SYNTHESIS
    // An accepted sample starts the multiply sequence in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg == ST_PMUL)
        else $error("sample transfer did not start the sequence");

    // The update step always ends with a result in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && out_free) |=> (state_reg == ST_IDLE && m_tvalid))
        else $error("update did not produce a result");

    // A new result only appears from the update step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_UPD)
        else $error("result appeared outside the update step");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the angle and speed tracking loop.
`timescale 1ns / 1ps

module testbench;
    import pllt_pkg::*;

    // Write to an index outside the register map; it must change nothing.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 1550;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 600000;

    localparam logic signed [63:0] SPEED_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SPEED_LO = 64'shFFFF_8000_0000_0000;

    // One result, laid out as on m_tdata: error on top, phase at the bottom.
    typedef struct packed {
        logic [15:0] error;
        logic [47:0] speed;
        logic [15:0] phase;
    } track_t;

    typedef enum {ROW_WRITE, ROW_SAMPLE, ROW_CHASE} row_kind_t;
    typedef enum {STYLE_TRACK, STYLE_CHASE, STYLE_NOISE} stim_style_t;
    typedef enum {PACE_FULL, PACE_COIN, PACE_SPARSE, PACE_RHYTHM} pace_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  index;
        logic [31:0] value;
        logic [15:0] phase;
        int          reps;
        bit          typed;
        track_t      want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    // Loop state and register copies used for prediction.
    logic [31:0] est_phase;
    logic [47:0] est_speed;
    logic [23:0] kp_gain;
    logic [31:0] ki_gain;
    logic [15:0] dt_step;

    track_t pending_results[$];
    int     fails      = 0;
    int     cycles     = 0;
    int     burst_left = 0;
    int     hold_req   = 0;
    int     hold_seen  = 0;
    int     stall_left = 0;
    int     mode_left  = 0;
    pace_t  rx_pace    = PACE_FULL;

    pll_angle_speed_tracker_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Advance the loop state by one measured angle and return the result.
    function automatic track_t track_sample(input logic [15:0] phase_in);
        logic [31:0]        e32;
        logic signed [63:0] err;
        logic signed [63:0] pterm;
        logic [63:0]        sum;
        logic [63:0]        inc;
        logic [31:0]        mag;
        logic [63:0]        gain_err;
        logic [95:0]        prod;
        logic [63:0]        quot;
        logic signed [63:0] delta;
        logic signed [63:0] speed_next;
        track_t             res;
        e32   = {phase_in, 16'h0000} - est_phase;
        err   = {{32{e32[31]}}, e32};
        pterm = (err * $signed({40'd0, kp_gain})) >>> 12;

        // Phase step: floor((speed + floor(kp*err / 2^12)) * dt / 2^24), wrapped to one turn.
        sum = {{16{est_speed[47]}}, est_speed} + pterm;
        inc = {32'd0, sum[55:24]} * {48'd0, dt_step}
            + (({40'd0, sum[23:0]} * {48'd0, dt_step}) >> 24);
        est_phase = est_phase + inc[31:0];

        // Speed step: exact floor of ki*err*dt / 2^36, then saturate.
        mag      = e32[31] ? (~e32 + 32'd1) : e32;
        gain_err = {32'd0, ki_gain} * {32'd0, mag};
        prod     = {32'd0, gain_err} * {80'd0, dt_step};
        quot     = {4'd0, prod[95:36]};
        if (e32[31])
            delta = -(quot + (prod[35:0] != 36'd0));
        else
            delta = quot;
        speed_next = $signed({{16{est_speed[47]}}, est_speed}) + delta;
        if (speed_next > SPEED_HI)
            speed_next = SPEED_HI;
        else if (speed_next < SPEED_LO)
            speed_next = SPEED_LO;
        est_speed = speed_next[47:0];

        res.phase = est_phase[31:16];
        res.speed = est_speed;
        res.error = e32[31:16];
        return res;
    endfunction

    // Offer one angle in bursts with random gaps; predict on the transfer.
    task automatic push_sample(input logic [15:0] phase_in, input bit typed,
                               input track_t want);
        track_t res;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= phase_in;
        do @(posedge aclk); while (!s_tready);
        res = track_sample(phase_in);
        pending_results.push_back(typed ? want : res);
        burst_left--;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (index)
            REG_PROP_GAIN:     kp_gain = value[23:0];
            REG_INTEG_GAIN:    ki_gain = value;
            REG_SAMPLE_PERIOD: dt_step = value[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Result side: ready pattern in modes, with a long hold-off on request.
    always @(posedge aclk) begin : rx_pacing
        logic rdy;
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rdy = 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen  = hold_req;
            stall_left = LONG_HOLD;
            rdy = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_pace   = pace_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 200);
            end
            mode_left = mode_left - 1;
            case (rx_pace)
                PACE_FULL:   rdy = 1'b1;
                PACE_COIN:   rdy = 1'($urandom_range(0, 1));
                PACE_SPARSE: rdy = ($urandom_range(0, 7) == 0);
                default:     rdy = (mode_left % 3 != 0);
            endcase
        end
        m_tready <= rdy;
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin : result_check
        track_t got;
        track_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                if (fails < 10)
                    $display("unexpected result transfer: %h", m_tdata);
                fails++;
            end else begin
                want = pending_results.pop_front();
                if (got.phase !== want.phase || got.speed !== want.speed ||
                    got.error !== want.error) begin
                    if (fails < 10)
                        $display("mismatch: phase exp %h got %h, speed exp %h got %h, %s%h got %h",
                                 want.phase, got.phase, want.speed, got.speed,
                                 "error exp ", want.error, got.error);
                    fails++;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("pll_angle_speed_tracker_core verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t   dir_rows[$];
        stim_row_t   row;
        stim_style_t style;
        logic [31:0] rotor;
        logic [31:0] rate;
        logic [31:0] pick;
        logic [15:0] phase_in;
        int          count;
        int          sent;
        int          phase_no;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_PROP_GAIN;
        cfg_wdata = '0;
        est_phase = '0;
        est_speed = '0;
        kp_gain   = PROP_GAIN_RST;
        ki_gain   = INTEG_GAIN_RST;
        dt_step   = SAMPLE_PERIOD_RST;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. With zero gains or a zero time step the estimates
        // stay at zero, so those results are plain to read off.
        dir_rows.push_back('{ROW_SAMPLE, REG_PROP_GAIN, 32'd0, 16'h4000, 1, 1'b1,
                             {16'h4000, 48'd0, 16'h0000}});
        // Error of exactly half a turn reads as minus pi.
        dir_rows.push_back('{ROW_SAMPLE, REG_PROP_GAIN, 32'd0, 16'h8000, 1, 1'b1,
                             {16'h8000, 48'd0, 16'h0000}});
        dir_rows.push_back('{ROW_SAMPLE, REG_PROP_GAIN, 32'd0, 16'h7FFF, 1, 1'b1,
                             {16'h7FFF, 48'd0, 16'h0000}});
        dir_rows.push_back('{ROW_SAMPLE, REG_PROP_GAIN, 32'd0, 16'hFFFF, 1, 1'b1,
                             {16'hFFFF, 48'd0, 16'h0000}});
        dir_rows.push_back('{ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF, 16'h0000, 1, 1'b0,
                             '0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PROP_GAIN, 32'd0, 16'h0000, 1, 1'b1,
                             {16'h0000, 48'd0, 16'h0000}});
        // Zero time step with the largest gains: nothing may move.
        dir_rows.push_back('{ROW_WRITE, REG_SAMPLE_PERIOD, 32'd0, 16'h0000, 1, 1'b0,
                             '0});
        dir_rows.push_back('{ROW_WRITE, REG_PROP_GAIN, 32'hFFFF_FFFF, 16'h0000, 1, 1'b0,
                             '0});
        dir_rows.push_back('{ROW_WRITE, REG_INTEG_GAIN, 32'hFFFF_FFFF, 16'h0000, 1, 1'b0,
                             '0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PROP_GAIN, 32'd0, 16'h8000, 1, 1'b1,
                             {16'h8000, 48'd0, 16'h0000}});
        dir_rows.push_back('{ROW_SAMPLE, REG_PROP_GAIN, 32'd0, 16'h1234, 1, 1'b1,
                             {16'h1234, 48'd0, 16'h0000}});
        dir_rows.push_back('{ROW_WRITE, REG_SAMPLE_PERIOD, {16'd0, SAMPLE_PERIOD_RST},
                             16'h0000, 1, 1'b0, '0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PROP_GAIN, 32'd0, 16'h8000, 1, 1'b0, '0});
        // Longest step and a near-maximal error every sample: the speed runs
        // into its upper limit and the phase steps wrap around the turn.
        dir_rows.push_back('{ROW_WRITE, REG_SAMPLE_PERIOD, 32'hFFFF_FFFF, 16'h0000, 1,
                             1'b0, '0});
        dir_rows.push_back('{ROW_CHASE, REG_PROP_GAIN, 32'd0, 16'h7FFF, 17, 1'b0, '0});
        dir_rows.push_back('{ROW_WRITE, REG_PROP_GAIN, 32'd0, 16'h0000, 1, 1'b0, '0});
        dir_rows.push_back('{ROW_WRITE, REG_INTEG_GAIN, 32'd0, 16'h0000, 1, 1'b0, '0});
        dir_rows.push_back('{ROW_SAMPLE, REG_PROP_GAIN, 32'd0, 16'hA5A5, 1, 1'b0, '0});

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            case (row.kind)
                ROW_WRITE: begin
                    settle();
                    write_reg(row.index, row.value);
                end
                ROW_SAMPLE: push_sample(row.phase, row.typed, row.want);
                default:
                    repeat (row.reps) push_sample(est_phase[31:16] + row.phase, 1'b0, '0);
            endcase
        end

        // Random part: phases of one setting each, mostly a rotor turning at
        // a steady rate with sensor noise, some chasing the limits, some noise.
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(0, 4))
                0:       pick = 32'd0;
                1:       pick = 32'hFFFF_FFFF;
                2, 3:    pick = $urandom_range(100, 3000) << 12;
                default: pick = $urandom;
            endcase
            write_reg(REG_PROP_GAIN, pick);
            case ($urandom_range(0, 4))
                0:       pick = 32'd0;
                1:       pick = 32'hFFFF_FFFF;
                2, 3:    pick = $urandom_range(1000, 1000000) << 12;
                default: pick = $urandom;
            endcase
            write_reg(REG_INTEG_GAIN, pick);
            case ($urandom_range(0, 5))
                0:       pick = {16'($urandom_range(0, 65535)), 16'd0};
                1:       pick = 32'd1;
                2:       pick = {16'($urandom_range(0, 65535)), 16'hFFFF};
                3:       pick = {16'd0, SAMPLE_PERIOD_RST};
                default: pick = $urandom;
            endcase
            write_reg(REG_SAMPLE_PERIOD, pick);

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: style = STYLE_TRACK;
                6, 7:             style = STYLE_CHASE;
                default:          style = STYLE_NOISE;
            endcase
            count = $urandom_range(40, 140);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            rate  = $urandom;
            rate  = {{8{rate[23]}}, rate[23:0]};
            rotor = est_phase + $urandom_range(0, 32'h00FF_FFFF);
            pick  = $urandom_range(0, 1);

            // Twice in the run the result side holds off while input continues.
            if (phase_no == 2 || phase_no == 9)
                hold_req++;

            for (int k = 0; k < count; k++) begin
                case (style)
                    STYLE_TRACK: begin
                        rotor    = rotor + rate;
                        phase_in = 16'(rotor[31:16] + $urandom_range(0, 64) - 32'd32);
                    end
                    STYLE_CHASE:
                        phase_in = est_phase[31:16] + (pick[0] ? 16'h7FFF : 16'h8001);
                    default:
                        phase_in = 16'($urandom);
                endcase
                push_sample(phase_in, 1'b0, '0);
            end
            sent += count;
            phase_no++;
        end

        settle();
        if (fails == 0)
            $display("pll_angle_speed_tracker_core verification clean");
        else
            $display("pll_angle_speed_tracker_core verification failed");
        $finish;
    end

endmodule

// ----- pll_angle_speed_tracker_core.f -----
hdl/pllt_pkg.sv
hdl/pllt_mul.sv
hdl/pll_angle_speed_tracker_core.sv
tb/testbench.sv
